// ===== design/ptts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptts_pkg
// Shared widths, opcodes, status codes and sequencer states of the periodic
// task tick scheduler.
// ----------------------------------------------------------------------------
package ptts_pkg;

  localparam int NUM_TASKS   = 8;
  localparam int TIMER_WIDTH = 32;
  localparam int SLOT_W      = 3;
  localparam int LEN_W       = $clog2(NUM_TASKS + 1);
  localparam int OPC_W       = 3;
  localparam int STAT_W      = 2;

  typedef enum logic [OPC_W-1:0] {
    OP_TICK = 3'd0,
    OP_EXEC = 3'd1,
    OP_ADD  = 3'd2,
    OP_DEL  = 3'd3,
    OP_INIT = 3'd4,
    OP_GET  = 3'd5
  } opcode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_ALREADY = 2'd1,
    ST_NONE    = 2'd2
  } status_t;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_TICK     = 8'b0000_0010,
    S_EXEC     = 8'b0000_0100,
    S_FIND_SRC = 8'b0000_1000,
    S_SHIFT    = 8'b0001_0000,
    S_FIND_DST = 8'b0010_0000,
    S_INIT     = 8'b0100_0000,
    S_REPLY    = 8'b1000_0000
  } state_t;

endpackage

// ===== design/periodic_task_tick_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler
// Bank of reload timers kept in an ordered active list and stopped list,
// walked one list entry per cycle, save while a result stalls, by a small sequencer.
// ----------------------------------------------------------------------------
// One command is taken at a time; in_ready is high only while the sequencer
// is idle, and the result register lets the next command in while the last
// result waits. A tick walks the active list one entry a cycle through a
// single shared decrementer. An exec walks the active list and gives one
// result per ready task, holding while the output stalls, or one ST_NONE
// result when nothing is ready. Add and delete search the source list, close
// the gap and search the target list, one entry a cycle.
// ----------------------------------------------------------------------------
module periodic_task_tick_scheduler (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ptts_pkg::OPC_W-1:0]        in_opcode,
  input  logic [ptts_pkg::SLOT_W-1:0]       in_task_slot,
  input  logic [ptts_pkg::TIMER_WIDTH-1:0]  in_period,
  input  logic [ptts_pkg::LEN_W-1:0]        in_position,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ptts_pkg::SLOT_W-1:0]       out_slot,
  output logic [ptts_pkg::STAT_W-1:0]       out_status,
  output logic                              out_last,
  output logic [ptts_pkg::LEN_W-1:0]        out_active_count,
  output logic [ptts_pkg::LEN_W-1:0]        out_stopped_count
);

  localparam int NT = ptts_pkg::NUM_TASKS;
  localparam int TW = ptts_pkg::TIMER_WIDTH;
  localparam int SW = ptts_pkg::SLOT_W;
  localparam int LW = ptts_pkg::LEN_W;

  ptts_pkg::state_t    state_r;
  ptts_pkg::opcode_t   op_r;
  ptts_pkg::status_t   st_r;
  logic [SW-1:0]       slot_r;
  logic [SW-1:0]       oslot_r;
  logic [LW-1:0]       pos_r;
  logic [TW-1:0]       per_r;
  logic [LW-1:0]       idx_r;

  logic [TW-1:0]       cd_r  [NT];
  logic [TW-1:0]       rl_r  [NT];
  logic [NT-1:0]       ready_r;
  logic [SW-1:0]       act_q_r [NT];
  logic [SW-1:0]       stp_q_r [NT];
  logic [LW-1:0]       act_len_r;
  logic [LW-1:0]       stp_len_r;

  logic                out_valid_r;
  logic [SW-1:0]       out_slot_r;
  ptts_pkg::status_t   out_status_r;
  logic                out_last_r;
  logic [LW-1:0]       out_act_r;
  logic [LW-1:0]       out_stp_r;

  logic                src_is_stp;
  logic [LW-1:0]       idx_p1;
  logic [LW-1:0]       pos_m1;
  logic [SW-1:0]       act_addr;
  logic [SW-1:0]       stp_addr;
  logic [SW-1:0]       act_rd;
  logic [SW-1:0]       stp_rd;
  logic [SW-1:0]       src_rd;
  logic [SW-1:0]       dst_rd;
  logic [LW-1:0]       src_len;
  logic [LW-1:0]       dst_len;
  logic [SW-1:0]       cd_addr;
  logic [TW-1:0]       cd_cur;
  logic [TW-1:0]       cd_dec;
  logic                ex_hit;
  logic [NT-1:0]       ex_rest;
  logic                can_load;
  logic                slot_oob;

  always_comb begin
    src_is_stp = (op_r == ptts_pkg::OP_ADD);
    idx_p1     = idx_r + LW'(1);
    pos_m1     = pos_r - LW'(1);
    act_addr   = idx_r[SW-1:0];
    stp_addr   = idx_r[SW-1:0];
    if (state_r == ptts_pkg::S_REPLY) begin
      act_addr = pos_m1[SW-1:0];
    end
    if (state_r == ptts_pkg::S_SHIFT) begin
      if (src_is_stp) begin
        stp_addr = idx_p1[SW-1:0];
      end else begin
        act_addr = idx_p1[SW-1:0];
      end
    end
    act_rd   = act_q_r[act_addr];
    stp_rd   = stp_q_r[stp_addr];
    src_rd   = src_is_stp ? stp_rd : act_rd;
    dst_rd   = src_is_stp ? act_rd : stp_rd;
    src_len  = src_is_stp ? stp_len_r : act_len_r;
    dst_len  = src_is_stp ? act_len_r : stp_len_r;
    cd_addr  = (state_r == ptts_pkg::S_TICK) ? act_rd : slot_r;
    cd_cur   = cd_r[cd_addr];
    cd_dec   = cd_cur - TW'(1);
    ex_hit   = ready_r[act_rd];
    ex_rest  = ready_r & ~(NT'(1) << act_rd);
    can_load = !out_valid_r || out_ready;
    slot_oob = LW'(in_task_slot) >= LW'(NT);
  end

  assign in_ready          = (state_r == ptts_pkg::S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_slot          = out_slot_r;
  assign out_status        = out_status_r;
  assign out_last          = out_last_r;
  assign out_active_count  = out_act_r;
  assign out_stopped_count = out_stp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ptts_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      act_len_r   <= '0;
      stp_len_r   <= '0;
      ready_r     <= '0;
      for (int i = 0; i < NT; i++) begin
        cd_r[i] <= '0;
        rl_r[i] <= '0;
      end
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ptts_pkg::S_IDLE: begin
          if (in_valid) begin
            op_r    <= ptts_pkg::opcode_t'(in_opcode);
            slot_r  <= in_task_slot;
            pos_r   <= in_position;
            per_r   <= in_period;
            idx_r   <= '0;
            st_r    <= ptts_pkg::ST_OK;
            oslot_r <= '0;
            unique case (in_opcode)
              ptts_pkg::OP_TICK: begin
                state_r <= (act_len_r == '0) ? ptts_pkg::S_REPLY : ptts_pkg::S_TICK;
              end
              ptts_pkg::OP_EXEC: begin
                if (ready_r == '0) begin
                  st_r    <= ptts_pkg::ST_NONE;
                  state_r <= ptts_pkg::S_REPLY;
                end else begin
                  state_r <= ptts_pkg::S_EXEC;
                end
              end
              ptts_pkg::OP_ADD, ptts_pkg::OP_DEL: begin
                if (slot_oob) begin
                  st_r    <= ptts_pkg::ST_NONE;
                  state_r <= ptts_pkg::S_REPLY;
                end else begin
                  state_r <= ptts_pkg::S_FIND_SRC;
                end
              end
              ptts_pkg::OP_INIT: begin
                if (slot_oob) begin
                  st_r    <= ptts_pkg::ST_NONE;
                  state_r <= ptts_pkg::S_REPLY;
                end else begin
                  state_r <= ptts_pkg::S_INIT;
                end
              end
              default: begin
                state_r <= ptts_pkg::S_REPLY;
              end
            endcase
          end
        end
        ptts_pkg::S_TICK: begin
          if (cd_cur != '0) begin
            if (cd_dec == '0) begin
              ready_r[act_rd] <= 1'b1;
              cd_r[act_rd]    <= rl_r[act_rd];
            end else begin
              cd_r[act_rd]    <= cd_dec;
            end
          end
          idx_r <= idx_p1;
          if (idx_p1 == act_len_r) begin
            state_r <= ptts_pkg::S_REPLY;
          end
        end
        ptts_pkg::S_EXEC: begin
          if (ex_hit) begin
            if (can_load) begin
              ready_r[act_rd] <= 1'b0;
              out_valid_r     <= 1'b1;
              out_slot_r      <= act_rd;
              out_status_r    <= ptts_pkg::ST_OK;
              out_last_r      <= (ex_rest == '0);
              out_act_r       <= act_len_r;
              out_stp_r       <= stp_len_r;
              if (ex_rest == '0) begin
                state_r <= ptts_pkg::S_IDLE;
              end else begin
                idx_r <= idx_p1;
              end
            end
          end else begin
            idx_r <= idx_p1;
          end
        end
        ptts_pkg::S_FIND_SRC: begin
          if (idx_r == src_len) begin
            idx_r   <= '0;
            state_r <= ptts_pkg::S_FIND_DST;
          end else if (src_rd == slot_r) begin
            ready_r[slot_r] <= 1'b0;
            cd_r[slot_r]    <= rl_r[slot_r];
            state_r         <= ptts_pkg::S_SHIFT;
          end else begin
            idx_r <= idx_p1;
          end
        end
        ptts_pkg::S_SHIFT: begin
          if (idx_p1 < src_len) begin
            if (src_is_stp) begin
              stp_q_r[idx_r[SW-1:0]] <= stp_rd;
            end else begin
              act_q_r[idx_r[SW-1:0]] <= act_rd;
            end
            idx_r <= idx_p1;
          end else begin
            if (src_is_stp) begin
              stp_len_r <= stp_len_r - LW'(1);
            end else begin
              act_len_r <= act_len_r - LW'(1);
            end
            idx_r   <= '0;
            state_r <= ptts_pkg::S_FIND_DST;
          end
        end
        ptts_pkg::S_FIND_DST: begin
          if (idx_r == dst_len) begin
            if (dst_len < LW'(NT)) begin
              if (src_is_stp) begin
                act_q_r[dst_len[SW-1:0]] <= slot_r;
                act_len_r                <= act_len_r + LW'(1);
              end else begin
                stp_q_r[dst_len[SW-1:0]] <= slot_r;
                stp_len_r                <= stp_len_r + LW'(1);
              end
            end
            state_r <= ptts_pkg::S_REPLY;
          end else if (dst_rd == slot_r) begin
            st_r    <= ptts_pkg::ST_ALREADY;
            state_r <= ptts_pkg::S_REPLY;
          end else begin
            idx_r <= idx_p1;
          end
        end
        ptts_pkg::S_INIT: begin
          cd_r[slot_r]    <= per_r;
          rl_r[slot_r]    <= per_r;
          ready_r[slot_r] <= 1'b0;
          state_r         <= ptts_pkg::S_REPLY;
        end
        ptts_pkg::S_REPLY: begin
          if (can_load) begin
            out_valid_r  <= 1'b1;
            out_slot_r   <= oslot_r;
            out_status_r <= st_r;
            out_last_r   <= 1'b1;
            out_act_r    <= act_len_r;
            out_stp_r    <= stp_len_r;
            if (op_r == ptts_pkg::OP_GET) begin
              if (pos_r != '0 && pos_r <= act_len_r) begin
                out_slot_r <= act_rd;
              end else begin
                out_status_r <= ptts_pkg::ST_NONE;
              end
            end
            state_r <= ptts_pkg::S_IDLE;
          end
        end
        default: begin
          state_r <= ptts_pkg::S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/ptts_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptts_checker
// Port-level checks of the periodic task tick scheduler, bound to the top.
// ----------------------------------------------------------------------------
module ptts_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [ptts_pkg::SLOT_W-1:0]       out_slot,
  input  logic [ptts_pkg::STAT_W-1:0]       out_status,
  input  logic                              out_last,
  input  logic [ptts_pkg::LEN_W-1:0]        out_active_count,
  input  logic [ptts_pkg::LEN_W-1:0]        out_stopped_count
);

  localparam int LW = ptts_pkg::LEN_W;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_slot) &&
      $stable(out_status) && $stable(out_last))
    else $error("result changed while stalled");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("command taken while previous one in flight");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (LW + 1)'(out_active_count) + (LW + 1)'(out_stopped_count)
      <= (LW + 1)'(ptts_pkg::NUM_TASKS))
    else $error("list lengths exceed task count");

  a_error_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ptts_pkg::ST_OK |-> out_last && out_slot == '0)
    else $error("error result not final or carries a slot");

endmodule

bind periodic_task_tick_scheduler ptts_checker u_ptts_checker (.*);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the periodic task tick scheduler.
// ----------------------------------------------------------------------------
// A queued driver feeds directed commands, then random command streams rich
// in ticks and execs so that timers actually fire. Every accepted command is
// run through a local model of the timer bank and both task lists, and each
// result transfer is compared field by field against the oldest prediction.
// Both handshakes are throttled at random in the first two of three phases of the run.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int OPC_W = ptts_pkg::OPC_W;
  localparam int SLOT_W = ptts_pkg::SLOT_W;
  localparam int TIMER_WIDTH = ptts_pkg::TIMER_WIDTH;
  localparam int LEN_W = ptts_pkg::LEN_W;
  localparam int STAT_W = ptts_pkg::STAT_W;
  localparam int NUM_TASKS = ptts_pkg::NUM_TASKS;

  localparam logic [OPC_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OPC_W-1:0] OP_SPARE_B = 3'd7;
  localparam int ACT          = 0;
  localparam int STP          = 1;
  localparam int RANDOM_CMDS  = 104;
  localparam int DRAIN_CYCLES = 40;
  localparam int LIMIT_CYCLES = 200000;

  typedef struct {
    logic [OPC_W-1:0]       opcode;
    logic [SLOT_W-1:0]      task_slot;
    logic [TIMER_WIDTH-1:0] period;
    logic [LEN_W-1:0]       position;
  } cmd_t;

  typedef struct {
    logic [SLOT_W-1:0]  slot;
    ptts_pkg::status_t  status;
    logic               last;
    logic [LEN_W-1:0]   act_cnt;
    logic [LEN_W-1:0]   stp_cnt;
  } result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [OPC_W-1:0]       in_opcode = '0;
  logic [SLOT_W-1:0]      in_task_slot = '0;
  logic [TIMER_WIDTH-1:0] in_period = '0;
  logic [LEN_W-1:0]       in_position = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [SLOT_W-1:0]      out_slot;
  logic [STAT_W-1:0]      out_status;
  logic                   out_last;
  logic [LEN_W-1:0]       out_active_count;
  logic [LEN_W-1:0]       out_stopped_count;

  periodic_task_tick_scheduler i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_task_slot      (in_task_slot),
    .in_period         (in_period),
    .in_position       (in_position),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_slot          (out_slot),
    .out_status        (out_status),
    .out_last          (out_last),
    .out_active_count  (out_active_count),
    .out_stopped_count (out_stopped_count)
  );

  // Model of the timer bank and the two ordered lists
  logic [TIMER_WIDTH-1:0] countdown [NUM_TASKS];
  logic [TIMER_WIDTH-1:0] reload_val [NUM_TASKS];
  logic                   ready_flag [NUM_TASKS];
  logic [SLOT_W-1:0]      lists [2][NUM_TASKS];
  int                     lens [2];

  cmd_t    pending_q [$];
  result_t expected_q [$];
  result_t want;
  int      total_cmds = 0;
  int      directed_cmds = 0;
  int      sent_cnt = 0;
  int      checked_cnt = 0;
  int      runs_cnt = 0;
  int      err_cnt = 0;
  int      cycle_cnt = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  task automatic report_mismatch(string msg);
    if (err_cnt < 20) $display("[%0t] MISMATCH: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic check_field(string name, int got, int exp);
    if (got != exp) report_mismatch($sformatf("%s got %0d, want %0d", name, got, exp));
  endtask

  task automatic push_result(logic [SLOT_W-1:0] slot, ptts_pkg::status_t st);
    result_t r;
    r.slot    = slot;
    r.status  = st;
    r.last    = 1'b0;
    r.act_cnt = LEN_W'(lens[ACT]);
    r.stp_cnt = LEN_W'(lens[STP]);
    expected_q.push_back(r);
  endtask

  function automatic ptts_pkg::status_t relocate(int slot, int src, int dst);
    int at;
    at = -1;
    for (int i = 0; i < lens[src]; i++) begin
      if (at < 0 && int'(lists[src][i]) == slot) at = i;
    end
    if (at >= 0) begin
      ready_flag[slot] = 1'b0;
      countdown[slot]  = reload_val[slot];
      for (int i = at; i < lens[src] - 1; i++) lists[src][i] = lists[src][i + 1];
      lens[src]--;
    end
    for (int i = 0; i < lens[dst]; i++) begin
      if (int'(lists[dst][i]) == slot) return ptts_pkg::ST_ALREADY;
    end
    if (lens[dst] < NUM_TASKS) begin
      lists[dst][lens[dst]] = SLOT_W'(slot);
      lens[dst]++;
    end
    return ptts_pkg::ST_OK;
  endfunction

  task automatic predict_schedule(cmd_t c);
    int                 s;
    int                 fired;
    ptts_pkg::status_t  st;
    logic [SLOT_W-1:0]  found;
    result_t            tail;
    st    = ptts_pkg::ST_OK;
    found = '0;
    fired = 0;
    case (c.opcode)
      ptts_pkg::OP_TICK: begin
        for (int i = 0; i < lens[ACT]; i++) begin
          s = int'(lists[ACT][i]);
          if (countdown[s] != '0) begin
            countdown[s] = countdown[s] - TIMER_WIDTH'(1);
            if (countdown[s] == '0) begin
              ready_flag[s] = 1'b1;
              countdown[s]  = reload_val[s];
            end
          end
        end
      end
      ptts_pkg::OP_EXEC: begin
        for (int i = 0; i < lens[ACT]; i++) begin
          s = int'(lists[ACT][i]);
          if (ready_flag[s]) begin
            ready_flag[s] = 1'b0;
            push_result(SLOT_W'(s), ptts_pkg::ST_OK);
            fired++;
          end
        end
        if (fired == 0) st = ptts_pkg::ST_NONE;
      end
      ptts_pkg::OP_ADD, ptts_pkg::OP_DEL, ptts_pkg::OP_INIT: begin
        if (int'(c.task_slot) >= NUM_TASKS) begin
          st = ptts_pkg::ST_NONE;
        end else if (c.opcode == ptts_pkg::OP_ADD) begin
          st = relocate(int'(c.task_slot), STP, ACT);
        end else if (c.opcode == ptts_pkg::OP_DEL) begin
          st = relocate(int'(c.task_slot), ACT, STP);
        end else begin
          countdown[c.task_slot]  = c.period;
          reload_val[c.task_slot] = c.period;
          ready_flag[c.task_slot] = 1'b0;
        end
      end
      ptts_pkg::OP_GET: begin
        if (int'(c.position) >= 1 && int'(c.position) <= lens[ACT]) begin
          found = lists[ACT][int'(c.position) - 1];
        end else begin
          st = ptts_pkg::ST_NONE;
        end
      end
      default: ;
    endcase
    if (fired == 0) push_result(found, st);
    tail = expected_q.pop_back();
    tail.last = 1'b1;
    expected_q.push_back(tail);
    runs_cnt += fired;
  endtask

  task automatic add_cmd(logic [OPC_W-1:0] op, logic [SLOT_W-1:0] slot,
                         logic [TIMER_WIDTH-1:0] per, logic [LEN_W-1:0] pos);
    cmd_t c;
    c.opcode    = op;
    c.task_slot = slot;
    c.period    = per;
    c.position  = pos;
    pending_q.push_back(c);
  endtask

  function automatic int send_idle_pct();
    if (sent_cnt < total_cmds / 3) return 24;
    if (sent_cnt < 2 * total_cmds / 3) return 68;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (sent_cnt < total_cmds / 3) return 68;
    if (sent_cnt < 2 * total_cmds / 3) return 24;
    return 0;
  endfunction

  // Driver: advance to the next command once the current one transfers
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        predict_schedule(cmd_t'{in_opcode, in_task_slot, in_period, in_position});
        sent_cnt <= sent_cnt + 1;
      end
      if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
        in_valid     <= 1'b1;
        in_opcode    <= pending_q[0].opcode;
        in_task_slot <= pending_q[0].task_slot;
        in_period    <= pending_q[0].period;
        in_position  <= pending_q[0].position;
        void'(pending_q.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each result transfer against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result slot %0d status %0d", out_slot,
                                  out_status));
      end else begin
        want = expected_q.pop_front();
        check_field("out_slot", int'(out_slot), int'(want.slot));
        check_field("out_status", int'(out_status), int'(want.status));
        check_field("out_last", int'(out_last), int'(want.last));
        check_field("out_active_count", int'(out_active_count), int'(want.act_cnt));
        check_field("out_stopped_count", int'(out_stopped_count), int'(want.stp_cnt));
        checked_cnt++;
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct());
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d of %0d commands sent, %0d results pending",
               cycle_cnt, sent_cnt, total_cmds, expected_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int                     r;
    int                     q;
    logic [OPC_W-1:0]       op;
    logic [SLOT_W-1:0]      slot;
    logic [TIMER_WIDTH-1:0] per;
    logic [LEN_W-1:0]       pos;

    for (int i = 0; i < NUM_TASKS; i++) begin
      countdown[i]  = '0;
      reload_val[i] = '0;
      ready_flag[i] = 1'b0;
    end
    lens[ACT] = 0;
    lens[STP] = 0;

    // Empty lists: get out of range, exec with nothing ready, idle tick
    add_cmd(ptts_pkg::OP_GET, 3'd0, '0, 4'd0);
    add_cmd(ptts_pkg::OP_GET, 3'd7, '1, 4'd15);
    add_cmd(ptts_pkg::OP_EXEC, 3'd0, '0, 4'd1);
    add_cmd(ptts_pkg::OP_TICK, 3'd0, '0, 4'd0);
    add_cmd(ptts_pkg::OP_INIT, 3'd0, 32'd1, 4'd0);
    add_cmd(ptts_pkg::OP_INIT, 3'd7, 32'hFFFF_FFFF, 4'd0);
    add_cmd(ptts_pkg::OP_INIT, 3'd3, 32'd0, 4'd0);
    add_cmd(ptts_pkg::OP_INIT, 3'd5, 32'd2, 4'd0);
    add_cmd(ptts_pkg::OP_ADD, 3'd0, '0, 4'd0);
    add_cmd(ptts_pkg::OP_ADD, 3'd7, '0, 4'd0);
    add_cmd(ptts_pkg::OP_ADD, 3'd3, '0, 4'd0);
    add_cmd(ptts_pkg::OP_ADD, 3'd5, '0, 4'd0);
    add_cmd(ptts_pkg::OP_ADD, 3'd0, '0, 4'd0);
    add_cmd(ptts_pkg::OP_TICK, 3'd0, '0, 4'd0);
    add_cmd(ptts_pkg::OP_TICK, 3'd0, '0, 4'd0);
    add_cmd(ptts_pkg::OP_EXEC, 3'd0, '0, 4'd0);
    add_cmd(ptts_pkg::OP_EXEC, 3'd0, '0, 4'd0);
    add_cmd(ptts_pkg::OP_GET, 3'd0, '0, 4'd1);
    add_cmd(ptts_pkg::OP_GET, 3'd0, '0, 4'd4);
    add_cmd(ptts_pkg::OP_GET, 3'd0, '0, 4'd5);
    add_cmd(ptts_pkg::OP_DEL, 3'd3, '0, 4'd0);
    add_cmd(ptts_pkg::OP_DEL, 3'd3, '0, 4'd0);
    add_cmd(ptts_pkg::OP_DEL, 3'd6, '0, 4'd0);
    add_cmd(ptts_pkg::OP_ADD, 3'd3, '0, 4'd0);
    add_cmd(OP_SPARE_A, 3'd2, 32'h5A5A_A5A5, 4'd9);
    add_cmd(OP_SPARE_B, 3'd4, 32'hA5A5_5A5A, 4'd6);
    directed_cmds = pending_q.size();

    // Short periods dominate so that ticks make tasks fire between execs
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      r    = int'($urandom_range(99));
      slot = SLOT_W'($urandom_range(NUM_TASKS - 1));
      per  = $urandom;
      pos  = LEN_W'($urandom_range(15));
      if (r < 34) begin
        op = ptts_pkg::OP_TICK;
      end else if (r < 52) begin
        op = ptts_pkg::OP_EXEC;
      end else if (r < 64) begin
        op = ptts_pkg::OP_ADD;
      end else if (r < 72) begin
        op = ptts_pkg::OP_DEL;
      end else if (r < 84) begin
        op = ptts_pkg::OP_INIT;
        q  = int'($urandom_range(9));
        if (q < 7) per = $urandom_range(1, 4);
        else if (q == 7) per = '0;
      end else if (r < 96) begin
        op = ptts_pkg::OP_GET;
        if ($urandom_range(3) != 0) pos = LEN_W'($urandom_range(1, NUM_TASKS));
      end else begin
        op = $urandom_range(1) ? OP_SPARE_A : OP_SPARE_B;
      end
      add_cmd(op, slot, per, pos);
    end
    total_cmds = pending_q.size();

    @(posedge clk);
    while (sent_cnt < total_cmds || expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_q.size()));
    end

    $display("Sent %0d commands (%0d directed), checked %0d results, %0d task runs",
             total_cmds, directed_cmds, checked_cnt, runs_cnt);
    $display("Mismatches: %0d", err_cnt);
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
